/* rtl/ci32alu_pkg.sv */
// types and constants shared by the checked 32-bit alu
`default_nettype none
package ci32alu_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned DIV_STEPS = 32;

   localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] MINUS_ONE = 32'shffff_ffff;

   typedef enum logic [3:0] {
      OP_NEG  = 4'd0,
      OP_LNOT = 4'd1,
      OP_ADD  = 4'd2,
      OP_SUB  = 4'd3,
      OP_MUL  = 4'd4,
      OP_DIV  = 4'd5,
      OP_MOD  = 4'd6,
      OP_EQ   = 4'd7,
      OP_NE   = 4'd8,
      OP_LT   = 4'd9,
      OP_LE   = 4'd10,
      OP_GT   = 4'd11,
      OP_GE   = 4'd12
   } op_type;

   // op sits in the lowest bits, matching the request tdata layout
   typedef struct packed {
      logic signed [WORD_W-1:0] second_operand;
      logic signed [WORD_W-1:0] first_operand;
      logic [3:0]               op;
   } in_type;

   typedef struct packed {
      logic              is_mul;
      logic              is_div;
      logic              is_mod;
      logic              neg_q;
      logic              neg_r;
      logic              ok;
      logic [WORD_W-1:0] res;
      logic [WORD_W-1:0] quo;  // dividend bits shift out, quotient bits shift in
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] dvs;
   } stage_type;

endpackage
`default_nettype wire

/* rtl/checked_int32_fold_alu.sv */
// Checked signed 32-bit ALU with a valid (folded) flag. Every request beat gives exactly one
// response beat, in order. The block is a pipeline of 36 register stages: an input register,
// an operand stage with the 32x32 multiplier, a stage that range-checks the product, 32 stages
// of a restoring divider that retire one quotient bit each, and the output register. A new
// beat is taken every cycle, a throughput of one beat per cycle, except that the whole
// pipeline holds while a response waits on rsp_tready.
`default_nettype none
module checked_int32_fold_alu import ci32alu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // op[3:0], first_operand[35:4], second_operand[67:36]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // folded[0], result_value[32:1]
);

   logic                     en;
   logic                     in_valid_ff;
   in_type                   in_ff;
   logic                     s1_valid_ff;
   stage_type                s1_ff, s1_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic                     vld_ff [0:DIV_STEPS];
   stage_type                pipe_ff [0:DIV_STEPS];
   stage_type                pipe_in [0:DIV_STEPS];
   logic                     out_valid_ff;
   logic                     folded_ff, folded_in;
   logic [WORD_W-1:0]        value_ff, value_in;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, value_ff, folded_ff};

   // operand stage
   always_comb begin
      logic signed [WORD_W-1:0] a, b;
      logic signed [WORD_W:0]   sum, dif;
      logic                     bad_div;
      a       = in_ff.first_operand;
      b       = in_ff.second_operand;
      sum     = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      dif     = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      bad_div = (b == '0) || (a == WORD_MIN && b == MINUS_ONE);
      prod_in = a * b;
      s1_in        = '0;
      s1_in.quo    = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
      s1_in.dvs    = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
      s1_in.neg_q  = a[WORD_W-1] ^ b[WORD_W-1];
      s1_in.neg_r  = a[WORD_W-1];
      s1_in.ok     = 1'b1;
      case (op_type'(in_ff.op))
         OP_NEG: begin
            s1_in.res = WORD_W'(-a);
            s1_in.ok  = (a != WORD_MIN);
         end
         OP_LNOT: s1_in.res = WORD_W'(a == '0);
         OP_ADD: begin
            s1_in.res = sum[WORD_W-1:0];
            s1_in.ok  = (sum[WORD_W] == sum[WORD_W-1]);
         end
         OP_SUB: begin
            s1_in.res = dif[WORD_W-1:0];
            s1_in.ok  = (dif[WORD_W] == dif[WORD_W-1]);
         end
         OP_MUL: s1_in.is_mul = 1'b1;
         OP_DIV: begin
            s1_in.is_div = 1'b1;
            s1_in.ok     = !bad_div;
         end
         OP_MOD: begin
            s1_in.is_mod = 1'b1;
            s1_in.ok     = !bad_div;
         end
         OP_EQ:  s1_in.res = WORD_W'(a == b);
         OP_NE:  s1_in.res = WORD_W'(a != b);
         OP_LT:  s1_in.res = WORD_W'(a < b);
         OP_LE:  s1_in.res = WORD_W'(a <= b);
         OP_GT:  s1_in.res = WORD_W'(a > b);
         OP_GE:  s1_in.res = WORD_W'(a >= b);
         default: s1_in.ok = 1'b0;
      endcase
   end

   // product range check
   always_comb begin
      pipe_in[0] = s1_ff;
      if (s1_ff.is_mul) begin
         pipe_in[0].res = prod_ff[WORD_W-1:0];
         pipe_in[0].ok  = (prod_ff[63:WORD_W-1] == {(64-WORD_W+1){prod_ff[WORD_W-1]}});
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_comb begin
         logic [WORD_W:0] trial;
         trial          = {pipe_ff[k].rem, pipe_ff[k].quo[WORD_W-1]};
         pipe_in[k+1]   = pipe_ff[k];
         if (trial >= {1'b0, pipe_ff[k].dvs}) begin
            pipe_in[k+1].rem = WORD_W'(trial - {1'b0, pipe_ff[k].dvs});
            pipe_in[k+1].quo = {pipe_ff[k].quo[WORD_W-2:0], 1'b1};
         end else begin
            pipe_in[k+1].rem = trial[WORD_W-1:0];
            pipe_in[k+1].quo = {pipe_ff[k].quo[WORD_W-2:0], 1'b0};
         end
      end
   end

   // sign fix-up and zeroing of unfolded results
   always_comb begin
      stage_type f;
      f         = pipe_ff[DIV_STEPS];
      folded_in = f.ok;
      value_in  = f.res;
      if (f.is_div) begin
         value_in = f.neg_q ? WORD_W'(-f.quo) : f.quo;
      end else if (f.is_mod) begin
         value_in = f.neg_r ? WORD_W'(-f.rem) : f.rem;
      end
      if (!f.ok) begin
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i <= DIV_STEPS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         in_valid_ff  <= req_tvalid;
         s1_valid_ff  <= in_valid_ff;
         vld_ff[0]    <= s1_valid_ff;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         out_valid_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff     <= in_type'(req_tdata[67:0]);
         s1_ff     <= s1_in;
         prod_ff   <= prod_in;
         for (int i = 0; i <= DIV_STEPS; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
         folded_ff <= folded_in;
         value_ff  <= value_in;
      end
   end

   a_zero_unfolded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !folded_ff |-> value_ff == '0)
      else $error("unfolded result not zero");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] && !en |=> vld_ff[DIV_STEPS])
      else $error("beat lost in divider tail during stall");

   a_stall_holds_head: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !en |=> in_valid_ff && $stable(in_ff))
      else $error("input stage changed during stall");

   a_move_to_output: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] && en |=> out_valid_ff)
      else $error("beat dropped before output register");

endmodule
`default_nettype wire
